FILE: hdl/lcs_pkg.sv
package lcs_pkg;

    localparam int COLUMN_OFFSET = 4;
    localparam int PAGE_COUNT    = 4;
    localparam int QUEUE_DEPTH   = 2;

    // operation codes
    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_ADDRESS = 2'd2;
    localparam logic [1:0] OP_ENCODED = 2'd3;

    // symbolic command ids
    localparam logic [4:0] CMD_DISPLAY_ON  = 5'd0;
    localparam logic [4:0] CMD_REVERSE     = 5'd1;
    localparam logic [4:0] CMD_ENTIRE_ON   = 5'd2;
    localparam logic [4:0] CMD_BIAS        = 5'd3;
    localparam logic [4:0] CMD_ADC         = 5'd4;
    localparam logic [4:0] CMD_SCAN_DIR    = 5'd5;
    localparam logic [4:0] CMD_START_LINE  = 5'd6;
    localparam logic [4:0] CMD_PAGE_ADDR   = 5'd7;
    localparam logic [4:0] CMD_POWER_CTRL  = 5'd8;
    localparam logic [4:0] CMD_REG_RATIO   = 5'd9;
    localparam logic [4:0] CMD_COL_UPPER   = 5'd10;
    localparam logic [4:0] CMD_COL_LOWER   = 5'd11;
    localparam logic [4:0] CMD_RMW_END     = 5'd12;
    localparam logic [4:0] CMD_RESET       = 5'd13;
    localparam logic [4:0] CMD_RMW         = 5'd14;
    localparam logic [4:0] CMD_VOLUME_MODE = 5'd15;
    localparam logic [4:0] CMD_NOP         = 5'd16;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic [6:0] column;
        logic [1:0] page;
        logic [4:0] command_id;
        logic [7:0] command_arg;
    } t_in_item;

    typedef struct packed {
        logic serial_bit;
        logic data_select;
        logic byte_end;
        logic last;
    } t_out_item;

    // one classified transaction: one or three bytes, first byte in [23:16]
    typedef struct packed {
        logic        three_bytes;
        logic        data_select;
        logic [23:0] bytes;
    } t_job;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } t_q_status;

endpackage

FILE: hdl/lcs_front.sv
module lcs_front import lcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  t_q_status i_q_status,
    output logic      o_stall,
    output logic      o_push,
    output t_job      o_job
);

    logic       r_reversed;
    logic [7:0] col;
    logic [7:0] page_cmd;

    function automatic logic [7:0] encode(input logic [4:0] id, input logic [7:0] arg);
        logic on;
        on = (arg != 8'd0);
        case (id)
            CMD_DISPLAY_ON:  encode = on ? 8'hAF : 8'hAE;
            CMD_REVERSE:     encode = on ? 8'hA6 : 8'hA7;
            CMD_ENTIRE_ON:   encode = on ? 8'hA5 : 8'hA4;
            CMD_BIAS:        encode = on ? 8'hA3 : 8'hA2;
            CMD_ADC:         encode = on ? 8'hA0 : 8'hA1;
            CMD_SCAN_DIR:    encode = on ? 8'hC8 : 8'hC0;
            CMD_START_LINE:  encode = 8'h40 | {2'b00, arg[5:0]};
            CMD_PAGE_ADDR:   encode = 8'hB0 | {4'h0, arg[3:0]};
            CMD_POWER_CTRL:  encode = 8'h28 | {4'h0, arg[3:0]};
            CMD_REG_RATIO:   encode = 8'h20 | {4'h0, arg[3:0]};
            CMD_COL_UPPER:   encode = 8'h10 | {4'h0, arg[3:0]};
            CMD_COL_LOWER:   encode = {4'h0, arg[3:0]};
            CMD_RMW_END:     encode = 8'hEE;
            CMD_RESET:       encode = 8'hE2;
            CMD_RMW:         encode = 8'hE0;
            CMD_VOLUME_MODE: encode = 8'h81;
            CMD_NOP:         encode = 8'hE3;
            default:         encode = 8'hE3;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reversed <= 1'b0;
        end else if (i_cfg_we) begin
            r_reversed <= i_cfg_data;
        end
    end

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        col      = {1'b0, i_item.column};
        if (!r_reversed) begin
            col = col + 8'(COLUMN_OFFSET);
        end
        page_cmd = 8'hB0 + 8'(i_item.page % PAGE_COUNT);

        o_job = '0;
        case (i_item.operation)
            OP_DATA: begin
                o_job.data_select = 1'b1;
                o_job.bytes       = {i_item.byte_value, 16'h0000};
            end
            OP_COMMAND: begin
                o_job.bytes       = {i_item.byte_value, 16'h0000};
            end
            OP_ADDRESS: begin
                o_job.three_bytes = 1'b1;
                o_job.bytes       = {page_cmd, 8'h10 + {4'h0, col[7:4]}, {4'h0, col[3:0]}};
            end
            OP_ENCODED: begin
                o_job.bytes = {encode(i_item.command_id, i_item.command_arg), 16'h0000};
            end
            default: begin
                o_job = '0;
            end
        endcase
    end

endmodule

FILE: hdl/lcs_queue.sv
module lcs_queue import lcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    t_job       r_mem [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_job           = r_mem[r_rd_ptr];
    assign o_status.count  = r_count;
    assign o_status.full   = (r_count == 2'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/lcs_back.sv
module lcs_back import lcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_job      i_job,
    output logic      o_pop,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_item o_item
);

    logic [23:0] r_shift;
    logic [4:0]  r_left;
    logic [2:0]  r_bit;
    logic        r_ds;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        advance;

    assign advance = !r_out_valid || !i_stall;
    assign o_pop   = !i_q_status.empty &&
                     ((r_left == 5'd0) || (advance && r_left == 5'd1));
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 5'd0;
            r_bit       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= (r_left != 5'd0);
                if (r_left != 5'd0) begin
                    r_out.serial_bit  <= r_shift[23];
                    r_out.data_select <= r_ds;
                    r_out.byte_end    <= (r_bit == 3'd7);
                    r_out.last        <= (r_left == 5'd1);
                end
            end
            // a pop replaces the finished job, otherwise shift on
            if (o_pop) begin
                r_shift <= i_job.bytes;
                r_ds    <= i_job.data_select;
                r_left  <= i_job.three_bytes ? 5'd24 : 5'd8;
                r_bit   <= 3'd0;
            end else if (advance && r_left != 5'd0) begin
                r_shift <= {r_shift[22:0], 1'b0};
                r_left  <= r_left - 5'd1;
                r_bit   <= r_bit + 3'd1;
            end
        end
    end

endmodule

FILE: hdl/lcd_command_serializer.sv
// lcd_command_serializer
// Turns LCD operation requests into a bit-serial command/data stream.
// Input channel (i_valid / o_stall, payload i_item): one transaction is one
//   operation: data byte, raw command, set address (three command bytes) or
//   an encoded symbolic command. Accepted when i_valid is high and o_stall low.
// Output channel (o_valid / i_stall, payload o_item): one transaction per bit,
//   MSB first, with register select, end-of-byte and end-of-run marks.
// Config: i_cfg_we / i_cfg_data write the reversed bit (mirrored display, no
//   column offset). Write only while the block is idle.
// Path: each accepted item goes job queue -> shift register -> output register.
// Throughput: one output bit per cycle unless the output stalls; an item is
//   8 bits (24 for set address), shifted out by the single shift register. A
//   2-entry job queue lets the front accept new transactions while bits go out.
// Reset (synchronous, active low): queue and serializer empty, reversed = 0.
// Output stall: the output register holds its bit; the serializer freezes and
//   the input stalls once the job queue fills.
module lcd_command_serializer import lcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_q_status q_status;
    t_job      push_job;
    t_job      head_job;
    logic      push;
    logic      pop;

    // front: config register, classify and encode each transaction
    lcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decouples the accept side from the bit shifter
    lcs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // back: shifts each job out one bit per cycle, unless the output stalls, into the output register
    lcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_job      (head_job),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

    // a run always ends on a byte boundary
    a_last_on_byte_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_item.last || o_item.byte_end))
        else $error("last mark away from byte end");

    // queue count never exceeds its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= 2'(QUEUE_DEPTH))
        else $error("job queue overflow");

    // nothing is popped from an empty queue
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // output is empty right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

FILE: tb/sv/tb_lcd_command_serializer.sv
module tb_lcd_command_serializer;
    import lcs_pkg::*;

    // Cycles with no transaction on either channel before the run is declared hung.
    // The longest quiet stretch in a correct run is a sender gap or stall burst
    // plus the block's pipeline delay, so this is many times over.
    localparam int HANG_LIMIT = 1000;

    // Serial bit stream predictor and expected-bit store.
    class lcd_stream_scoreboard;
        bit        reversed;
        t_out_item pending_bits[$];
        int        errors;

        function new();
            reversed = 1'b0;
            errors   = 0;
        endfunction

        // Symbolic command id plus argument to the controller's command byte.
        function logic [7:0] encode_symbolic(logic [4:0] id, logic [7:0] arg);
            logic on;
            on = (arg != 8'h00);
            case (id)
                CMD_DISPLAY_ON:  return on ? 8'hAF : 8'hAE;
                CMD_REVERSE:     return on ? 8'hA6 : 8'hA7;
                CMD_ENTIRE_ON:   return on ? 8'hA5 : 8'hA4;
                CMD_BIAS:        return on ? 8'hA3 : 8'hA2;
                CMD_ADC:         return on ? 8'hA0 : 8'hA1;
                CMD_SCAN_DIR:    return on ? 8'hC8 : 8'hC0;
                CMD_START_LINE:  return 8'h40 | (arg & 8'h3F);
                CMD_PAGE_ADDR:   return 8'hB0 | (arg & 8'h0F);
                CMD_POWER_CTRL:  return 8'h28 | (arg & 8'h0F);
                CMD_REG_RATIO:   return 8'h20 | (arg & 8'h0F);
                CMD_COL_UPPER:   return 8'h10 | (arg & 8'h0F);
                CMD_COL_LOWER:   return arg & 8'h0F;
                CMD_RMW_END:     return 8'hEE;
                CMD_RESET:       return 8'hE2;
                CMD_RMW:         return 8'hE0;
                CMD_VOLUME_MODE: return 8'h81;
                default:         return 8'hE3;    // NOP, also ids past the table
            endcase
        endfunction

        // Queue one byte as eight bits, MSB first.
        function void push_byte(logic [7:0] value, logic ds, logic final_byte);
            t_out_item b;
            for (int i = 7; i >= 0; i--) begin
                b.serial_bit  = value[i];
                b.data_select = ds;
                b.byte_end    = (i == 0);
                b.last        = final_byte && (i == 0);
                pending_bits.push_back(b);
            end
        endfunction

        // Called on every accepted request transaction.
        function void note_request(t_in_item req);
            logic [7:0] col;
            int         pg;
            case (req.operation)
                OP_DATA:    push_byte(req.byte_value, 1'b1, 1'b1);
                OP_COMMAND: push_byte(req.byte_value, 1'b0, 1'b1);
                OP_ADDRESS: begin
                    col = {1'b0, req.column};
                    if (!reversed) begin
                        col = 8'(col + COLUMN_OFFSET);
                    end
                    pg = int'(req.page) % PAGE_COUNT;
                    push_byte(8'(8'hB0 + pg), 1'b0, 1'b0);
                    push_byte(8'(8'h10 + (col >> 4)), 1'b0, 1'b0);
                    push_byte({4'h0, col[3:0]}, 1'b0, 1'b1);
                end
                default:    push_byte(encode_symbolic(req.command_id, req.command_arg),
                                      1'b0, 1'b1);
            endcase
        endfunction

        // Called on every accepted output bit transaction.
        function void check_bit(t_out_item got);
            t_out_item want;
            if (pending_bits.size() == 0) begin
                $error("unexpected output bit %b with nothing pending", got);
                errors++;
                return;
            end
            want = pending_bits.pop_front();
            if (got.serial_bit !== want.serial_bit) begin
                $error("serial_bit: expected %0b, got %0b", want.serial_bit, got.serial_bit);
                errors++;
            end
            if (got.data_select !== want.data_select) begin
                $error("data_select: expected %0b, got %0b", want.data_select,
                       got.data_select);
                errors++;
            end
            if (got.byte_end !== want.byte_end) begin
                $error("byte_end: expected %0b, got %0b", want.byte_end, got.byte_end);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_bits.size();
        endfunction
    endclass

    // All block inputs start at known values.
    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_cfg_we   = 1'b0;
    logic      i_cfg_data = 1'b0;
    logic      i_valid    = 1'b0;
    t_in_item  i_item     = '0;
    logic      i_stall    = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    lcd_stream_scoreboard bit_board = new();

    // Last phase runs without stalls or gaps to check full-rate streaming.
    bit steady_phase = 1'b0;
    int stall_len;
    int quiet_cycles = 0;

    lcd_command_serializer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request and hold it until the block takes it. Back-to-back
    // calls keep i_valid high; the payload just changes at the next falling edge.
    task automatic send_request(input t_in_item req);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= req;
        do @(posedge i_clk); while (o_stall);
        bit_board.note_request(req);
    endtask

    // Drop i_valid for a burst of idle cycles.
    task automatic idle_requests(input int cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stop sending and let every pending bit drain out, plus a small margin
    // for the pipeline to settle before a register write.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (bit_board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only issued while the block is idle, so the model switches at the same time.
    task automatic write_reversed(input logic value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        bit_board.reversed = value;
    endtask

    // Random requests. Unused fields stay random; ids lean toward the defined
    // table, flag args are often zero, columns often sit near the wrap point.
    task automatic random_phase(input int count);
        t_in_item req;
        for (int n = 0; n < count; n++) begin
            req = t_in_item'($urandom);
            if ($urandom_range(0, 4) != 0) begin
                req.command_id = 5'($urandom_range(0, 16));
            end
            if ($urandom_range(0, 3) == 0) begin
                req.command_arg = 8'h00;
            end
            if ($urandom_range(0, 5) == 0) begin
                req.column = 7'($urandom_range(120, 127));
            end
            if (!steady_phase && $urandom_range(0, 3) == 0) begin
                idle_requests($urandom_range(1, 12));
            end
            send_request(req);
        end
    endtask

    // Directed opener: both data extremes, raw command, address at the column
    // ends (including the offset carrying into the upper nibble and past 127),
    // every symbolic command, and an id beyond the table that must become NOP.
    task automatic directed_phase();
        t_in_item req;
        req = t_in_item'($urandom); req.operation = OP_DATA;    req.byte_value = 8'h00;
        send_request(req);
        req = t_in_item'($urandom); req.operation = OP_DATA;    req.byte_value = 8'hFF;
        send_request(req);
        req = t_in_item'($urandom); req.operation = OP_COMMAND; req.byte_value = 8'hFF;
        send_request(req);
        req = t_in_item'($urandom); req.operation = OP_ADDRESS;
        req.column = 7'd0;   req.page = 2'd0;
        send_request(req);
        req = t_in_item'($urandom); req.operation = OP_ADDRESS;
        req.column = 7'd127; req.page = 2'd3;
        send_request(req);
        req = t_in_item'($urandom); req.operation = OP_ADDRESS;
        req.column = 7'd124; req.page = 2'd1;
        send_request(req);
        for (int id = 0; id <= 17; id++) begin
            req = t_in_item'($urandom);
            req.operation   = OP_ENCODED;
            req.command_id  = (id == 17) ? 5'd31 : 5'(id);
            req.command_arg = id[0] ? 8'h00 : 8'hFF;
            send_request(req);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Random stall bursts; i_stall always drops between two bursts.
    always begin
        @(negedge i_clk);
        if (!steady_phase && $urandom_range(0, 4) == 0) begin
            stall_len = $urandom_range(1, 12);
            i_stall <= 1'b1;
            repeat (stall_len) @(negedge i_clk);
            i_stall <= 1'b0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Every bit transaction accepted at the rising edge goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            bit_board.check_bit(o_item);
        end
    end

    // Hang detection: any transaction on either channel resets the count.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("lcd_command_serializer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Normal orientation: column offset applied.
        write_reversed(1'b0);
        directed_phase();
        random_phase(70);

        // Sender holds off until the stream is fully drained, then mirror.
        wait_drained();
        write_reversed(1'b1);
        random_phase(70);

        // Back to normal orientation, full rate on both sides.
        wait_drained();
        write_reversed(1'b0);
        steady_phase = 1'b1;
        random_phase(60);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (bit_board.errors == 0 && bit_board.pending() == 0) begin
            $display("lcd_command_serializer test passed");
        end else begin
            $display("lcd_command_serializer test failed");
        end
        $finish;
    end

endmodule
